// ===== sv/rht_pkg.sv =====
// ----------------------------------------------------------------------------
// Reference-counted handle table: shared definitions
// Word layouts, command and status codes, and the internal control structs
// that pass between the sequencer, the slot store and the entry pool.
// ----------------------------------------------------------------------------
package rht_pkg;

  localparam int POOL_ENTRIES_DEF = 64;
  localparam int OWNERS_DEF       = 16;
  localparam int SLOTS_DEF        = 16;

  localparam int CMD_W    = 3;
  localparam int OWNER_W  = 4;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 6;
  localparam int REFS_W   = 5;

  localparam logic [REFS_W-1:0] REFS_MAX = 5'd31;

  // Free entries are searched this many at a time.
  localparam int SCAN_W = 8;

  localparam logic [CMD_W-1:0] CMD_ALLOC_FROM = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC_AT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_SLOT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FREE_TABLE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COPY_TABLE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

  localparam logic [1:0] POP_NONE    = 2'd0;
  localparam logic [1:0] POP_TAKE    = 2'd1;
  localparam logic [1:0] POP_RELEASE = 2'd2;
  localparam logic [1:0] POP_INCR    = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [OWNER_W-1:0] owner;
    logic [SLOT_W-1:0]  slot;
    logic [OWNER_W-1:0] source_owner;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [ENTRY_W-1:0]  entry_out;
    logic                entry_valid;
  } out_word_t;

  typedef struct packed {
    logic [1:0] op;
  } pool_req_t;

  typedef struct packed {
    logic ready;
    logic done;
    logic ok;
  } pool_rsp_t;

  typedef struct packed {
    logic rd_en;
    logic valid_we;
    logic valid_wd;
    logic entry_we;
  } slot_ctl_t;

endpackage

// ===== sv/rht_ref_alu.sv =====
// ----------------------------------------------------------------------------
// Reference count unit
// Saturating increment, and release that reports when the count runs out.
// ----------------------------------------------------------------------------
module rht_ref_alu
  import rht_pkg::*;
(
  input  logic              incr,
  input  logic [REFS_W-1:0] refs,
  output logic [REFS_W-1:0] refs_next,
  output logic              cleared
);

  always_comb begin
    cleared = 1'b0;
    if (incr) begin
      refs_next = (refs == REFS_MAX) ? refs : refs + REFS_W'(1);
    end else if (refs <= REFS_W'(1)) begin
      refs_next = '0;
      cleared   = 1'b1;
    end else begin
      refs_next = refs - REFS_W'(1);
    end
  end

endmodule

// ===== sv/rht_pool.sv =====
// ----------------------------------------------------------------------------
// Descriptor entry pool
// In-use flags, reference count memory with a clearing pass after reset,
// a first-fit search over the flags and the shared reference count unit.
// ----------------------------------------------------------------------------
module rht_pool
  import rht_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pool_req_t                       req,
  input  logic [$clog2(POOL_ENTRIES)-1:0] req_entry,
  output pool_rsp_t                       rsp,
  output logic [$clog2(POOL_ENTRIES)-1:0] rsp_entry
);

  localparam int EW     = $clog2(POOL_ENTRIES);
  localparam int CHUNKS = (POOL_ENTRIES + SCAN_W - 1) / SCAN_W;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PADW   = CHUNKS * SCAN_W;
  localparam int PEW    = $clog2(SCAN_W);

  localparam logic [1:0] P_CLEAR = 2'd0;
  localparam logic [1:0] P_IDLE  = 2'd1;
  localparam logic [1:0] P_UPD   = 2'd2;
  localparam logic [1:0] P_SCAN  = 2'd3;

  logic [1:0]              state;
  logic [EW-1:0]           clr_cnt;
  logic [CW-1:0]           chunk;
  logic [EW-1:0]           ent_r;
  logic                    incr_r;
  logic [POOL_ENTRIES-1:0] in_use;
  logic [REFS_W-1:0]       refs_rd;
  logic [REFS_W-1:0]       refs_mem [POOL_ENTRIES];

  logic [POOL_ENTRIES-1:0] free_vec;
  logic [PADW-1:0]         free_pad;
  logic [SCAN_W-1:0]       chunk_bits;
  logic                    pe_hit;
  logic [PEW-1:0]          pe_idx;
  logic [EW-1:0]           found_idx;
  logic                    last_chunk;

  logic [REFS_W-1:0]       alu_refs;
  logic                    alu_clr;

  logic                    mem_we;
  logic [EW-1:0]           mem_addr;
  logic [REFS_W-1:0]       mem_wd;
  logic                    rd_en;

  rht_ref_alu u_alu (
    .incr      (incr_r),
    .refs      (refs_rd),
    .refs_next (alu_refs),
    .cleared   (alu_clr)
  );

  // Padding entries beyond the pool read as taken.
  assign free_vec   = ~in_use;
  assign free_pad   = PADW'(free_vec);
  assign chunk_bits = free_pad[chunk*SCAN_W +: SCAN_W];
  assign last_chunk = (chunk == CW'(CHUNKS - 1));
  assign found_idx  = EW'({chunk, pe_idx});

  always_comb begin
    pe_hit = |chunk_bits;
    pe_idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (chunk_bits[i]) pe_idx = PEW'(i);
    end
  end

  always_comb begin
    rsp.ready = (state != P_CLEAR);
    rsp.done  = 1'b0;
    rsp.ok    = 1'b0;
    rsp_entry = found_idx;
    mem_we    = 1'b0;
    mem_addr  = ent_r;
    mem_wd    = alu_refs;
    rd_en     = 1'b0;
    unique case (state)
      P_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
        mem_wd   = '0;
      end
      P_IDLE: begin
        rd_en = (req.op == POP_RELEASE) || (req.op == POP_INCR);
      end
      P_UPD: begin
        mem_we   = 1'b1;
        rsp.done = 1'b1;
        rsp.ok   = 1'b1;
      end
      P_SCAN: begin
        if (pe_hit) begin
          mem_we   = 1'b1;
          mem_addr = found_idx;
          mem_wd   = REFS_W'(1);
          rsp.done = 1'b1;
          rsp.ok   = 1'b1;
        end else if (last_chunk) begin
          rsp.done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= P_CLEAR;
      clr_cnt <= '0;
      in_use  <= '0;
    end else begin
      unique case (state)
        P_CLEAR: begin
          clr_cnt <= clr_cnt + EW'(1);
          if (clr_cnt == EW'(POOL_ENTRIES - 1)) state <= P_IDLE;
        end
        P_IDLE: begin
          if (req.op == POP_RELEASE || req.op == POP_INCR) begin
            ent_r  <= req_entry;
            incr_r <= (req.op == POP_INCR);
            state  <= P_UPD;
          end else if (req.op == POP_TAKE) begin
            chunk <= '0;
            state <= P_SCAN;
          end
        end
        P_UPD: begin
          if (alu_clr) in_use[ent_r] <= 1'b0;
          state <= P_IDLE;
        end
        P_SCAN: begin
          if (pe_hit) begin
            in_use[found_idx] <= 1'b1;
            state             <= P_IDLE;
          end else if (last_chunk) begin
            state <= P_IDLE;
          end else begin
            chunk <= chunk + CW'(1);
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) refs_mem[mem_addr] <= mem_wd;
    if (rd_en) refs_rd <= refs_mem[req_entry];
  end

endmodule

// ===== sv/rht_slot_store.sv =====
// ----------------------------------------------------------------------------
// Owner slot store
// Per-slot valid flags in flip-flops and the slot-to-entry memory.
// ----------------------------------------------------------------------------
module rht_slot_store
  import rht_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int OWNERS       = OWNERS_DEF,
  parameter int SLOTS        = SLOTS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  slot_ctl_t                                           ctl,
  input  logic [((OWNERS*SLOTS > 1) ? $clog2(OWNERS*SLOTS) : 1)-1:0] rd_idx,
  input  logic [((OWNERS*SLOTS > 1) ? $clog2(OWNERS*SLOTS) : 1)-1:0] wr_idx,
  input  logic [$clog2(POOL_ENTRIES)-1:0]                     wr_entry,
  output logic                                                rd_valid,
  output logic [$clog2(POOL_ENTRIES)-1:0]                     rd_entry
);

  localparam int DEPTH = OWNERS * SLOTS;
  localparam int EW    = $clog2(POOL_ENTRIES);

  logic [DEPTH-1:0] slot_valid;
  logic [EW-1:0]    slot_entry [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctl.valid_we) begin
      slot_valid[wr_idx] <= ctl.valid_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.entry_we) slot_entry[wr_idx] <= wr_entry;
    if (ctl.rd_en) rd_entry <= slot_entry[rd_idx];
  end

  assign rd_valid = slot_valid[rd_idx];

endmodule

// ===== sv/rht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Command sequencer
// Decodes one command word, walks the slots it touches, drives the entry
// pool and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module rht_ctrl
  import rht_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int OWNERS       = OWNERS_DEF,
  parameter int SLOTS        = SLOTS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                in_valid,
  output logic                                                in_ready,
  input  in_word_t                                            in_word,
  output logic                                                out_valid,
  input  logic                                                out_ready,
  output out_word_t                                           out_word,
  output pool_req_t                                           pool_req,
  output logic [$clog2(POOL_ENTRIES)-1:0]                     pool_entry_req,
  input  pool_rsp_t                                           pool_rsp,
  input  logic [$clog2(POOL_ENTRIES)-1:0]                     pool_entry,
  output slot_ctl_t                                           slot_ctl,
  output logic [((OWNERS*SLOTS > 1) ? $clog2(OWNERS*SLOTS) : 1)-1:0] rd_idx,
  output logic [((OWNERS*SLOTS > 1) ? $clog2(OWNERS*SLOTS) : 1)-1:0] wr_idx,
  output logic [$clog2(POOL_ENTRIES)-1:0]                     wr_entry,
  input  logic                                                rd_valid,
  input  logic [$clog2(POOL_ENTRIES)-1:0]                     rd_entry
);

  localparam int IW = (OWNERS * SLOTS > 1) ? $clog2(OWNERS * SLOTS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_AF_CHK    = 4'd1;
  localparam logic [3:0] S_AT_CHK    = 4'd2;
  localparam logic [3:0] S_TAKE_WAIT = 4'd3;
  localparam logic [3:0] S_REL_CHK   = 4'd4;
  localparam logic [3:0] S_REL_ISSUE = 4'd5;
  localparam logic [3:0] S_REL_WAIT  = 4'd6;
  localparam logic [3:0] S_CP_CHK    = 4'd7;
  localparam logic [3:0] S_CP_ISSUE  = 4'd8;
  localparam logic [3:0] S_CP_WAIT   = 4'd9;
  localparam logic [3:0] S_RESP      = 4'd10;

  logic [3:0]         state, state_next;
  logic [CMD_W-1:0]   cmd_r, cmd_next;
  logic [OWNER_W-1:0] own_r, own_next;
  logic [OWNER_W-1:0] src_r, src_next;
  logic [SW-1:0]      scnt, scnt_next;
  out_word_t          res, res_next;
  logic               out_valid_next;
  out_word_t          out_word_next;

  logic               own_in_ok, src_in_ok, slot_in_ok;
  logic [IW-1:0]      own_idx, src_idx;
  logic               last;
  logic               rd_src;
  logic               rel_adv, cp_adv;

  assign own_in_ok  = (9'(in_word.owner) < 9'(OWNERS));
  assign src_in_ok  = (9'(in_word.source_owner) < 9'(OWNERS));
  assign slot_in_ok = (9'(in_word.slot) < 9'(SLOTS));

  assign own_idx = IW'(IW'(own_r) * IW'(SLOTS)) + IW'(scnt);
  assign src_idx = IW'(IW'(src_r) * IW'(SLOTS)) + IW'(scnt);
  assign last    = (scnt == SW'(SLOTS - 1));

  assign rd_idx         = rd_src ? src_idx : own_idx;
  assign wr_idx         = own_idx;
  assign wr_entry       = (state == S_CP_ISSUE) ? rd_entry : pool_entry;
  assign pool_entry_req = rd_entry;
  assign in_ready       = (state == S_IDLE) && pool_rsp.ready;

  always_comb begin
    state_next     = state;
    cmd_next       = cmd_r;
    own_next       = own_r;
    src_next       = src_r;
    scnt_next      = scnt;
    res_next       = res;
    out_valid_next = out_valid;
    out_word_next  = out_word;
    pool_req.op    = POP_NONE;
    slot_ctl       = '0;
    rd_src         = 1'b0;
    rel_adv        = 1'b0;
    cp_adv         = 1'b0;

    if (out_valid && out_ready) out_valid_next = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_next  = in_word.cmd;
          own_next  = in_word.owner;
          src_next  = in_word.source_owner;
          scnt_next = '0;
          res_next  = '0;
          if (in_word.cmd <= CMD_COPY_TABLE && !own_in_ok) begin
            res_next.status = ST_NO_SPACE;
            state_next      = S_RESP;
          end else begin
            unique case (in_word.cmd)
              CMD_ALLOC_FROM: begin
                if (!slot_in_ok) begin
                  res_next.status = ST_NO_SPACE;
                  state_next      = S_RESP;
                end else begin
                  scnt_next  = SW'(in_word.slot);
                  state_next = S_AF_CHK;
                end
              end
              CMD_ALLOC_AT: begin
                if (!slot_in_ok) begin
                  res_next.status = ST_NO_SPACE;
                  state_next      = S_RESP;
                end else begin
                  scnt_next  = SW'(in_word.slot);
                  state_next = S_AT_CHK;
                end
              end
              CMD_FREE_SLOT: begin
                if (!slot_in_ok) begin
                  state_next = S_RESP;
                end else begin
                  scnt_next  = SW'(in_word.slot);
                  state_next = S_REL_CHK;
                end
              end
              CMD_FREE_TABLE: begin
                state_next = S_REL_CHK;
              end
              CMD_COPY_TABLE: begin
                if (!src_in_ok) begin
                  res_next.status = ST_NO_SPACE;
                  state_next      = S_RESP;
                end else begin
                  state_next = S_REL_CHK;
                end
              end
              default: state_next = S_RESP;
            endcase
          end
        end
      end

      S_AF_CHK: begin
        if (rd_valid) begin
          if (last) begin
            res_next.status = ST_NO_SPACE;
            state_next      = S_RESP;
          end else begin
            scnt_next = scnt + SW'(1);
          end
        end else begin
          pool_req.op = POP_TAKE;
          state_next  = S_TAKE_WAIT;
        end
      end

      S_AT_CHK: begin
        if (rd_valid) begin
          res_next.status = ST_OCCUPIED;
          state_next      = S_RESP;
        end else begin
          pool_req.op = POP_TAKE;
          state_next  = S_TAKE_WAIT;
        end
      end

      S_TAKE_WAIT: begin
        if (pool_rsp.done) begin
          if (pool_rsp.ok) begin
            slot_ctl.valid_we    = 1'b1;
            slot_ctl.valid_wd    = 1'b1;
            slot_ctl.entry_we    = 1'b1;
            res_next.entry_out   = ENTRY_W'(pool_entry);
            res_next.entry_valid = 1'b1;
            if (cmd_r == CMD_ALLOC_FROM) res_next.slot_out = SLOT_W'(scnt);
          end else if (cmd_r == CMD_ALLOC_FROM) begin
            res_next.status = ST_NO_SPACE;
          end
          // A failed take at a given slot still answers ok with no entry.
          state_next = S_RESP;
        end
      end

      S_REL_CHK: begin
        if (rd_valid) begin
          slot_ctl.rd_en    = 1'b1;
          slot_ctl.valid_we = 1'b1;
          slot_ctl.valid_wd = 1'b0;
          state_next        = S_REL_ISSUE;
        end else begin
          rel_adv = 1'b1;
        end
      end

      S_REL_ISSUE: begin
        pool_req.op = POP_RELEASE;
        state_next  = S_REL_WAIT;
      end

      S_REL_WAIT: begin
        if (pool_rsp.done) rel_adv = 1'b1;
      end

      S_CP_CHK: begin
        rd_src = 1'b1;
        if (rd_valid) begin
          slot_ctl.rd_en = 1'b1;
          state_next     = S_CP_ISSUE;
        end else begin
          cp_adv = 1'b1;
        end
      end

      S_CP_ISSUE: begin
        slot_ctl.valid_we = 1'b1;
        slot_ctl.valid_wd = 1'b1;
        slot_ctl.entry_we = 1'b1;
        pool_req.op       = POP_INCR;
        state_next        = S_CP_WAIT;
      end

      S_CP_WAIT: begin
        if (pool_rsp.done) cp_adv = 1'b1;
      end

      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_word_next  = res;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // The destination table is emptied before a copy starts.
    if (rel_adv) begin
      if (cmd_r == CMD_FREE_SLOT) begin
        state_next = S_RESP;
      end else if (last) begin
        if (cmd_r == CMD_COPY_TABLE) begin
          scnt_next  = '0;
          state_next = S_CP_CHK;
        end else begin
          state_next = S_RESP;
        end
      end else begin
        scnt_next  = scnt + SW'(1);
        state_next = S_REL_CHK;
      end
    end

    if (cp_adv) begin
      if (last) begin
        state_next = S_RESP;
      end else begin
        scnt_next  = scnt + SW'(1);
        state_next = S_CP_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_next;
    own_r    <= own_next;
    src_r    <= src_next;
    scnt     <= scnt_next;
    res      <= res_next;
    out_word <= out_word_next;
  end

endmodule

// ===== sv/refcounted_handle_table_top.sv =====
// An occupied slot on a table walk passes through a check, an issue and a wait state.
// Allocation searches the pool in groups of 8 entries, at most (POOL_ENTRIES+7)/8 groups.
// free_table walks every slot of the owner; copy_table first empties the destination table, then walks the source.
// One command word is in flight at a time; the next is taken once its result is registered.
// After reset the count memory is cleared entry by entry, with in_ready low.
// ----------------------------------------------------------------------------
// Reference-counted handle table
// Per-owner slot tables naming entries of a shared, reference-counted pool.
// ----------------------------------------------------------------------------
module refcounted_handle_table_top
  import rht_pkg::*;
#(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int OWNERS       = OWNERS_DEF,
  parameter int SLOTS        = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int IW = (OWNERS * SLOTS > 1) ? $clog2(OWNERS * SLOTS) : 1;
  localparam int EW = $clog2(POOL_ENTRIES);

  pool_req_t     pool_req;
  pool_rsp_t     pool_rsp;
  logic [EW-1:0] pool_entry_req;
  logic [EW-1:0] pool_entry;
  slot_ctl_t     slot_ctl;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_entry;
  logic          rd_valid;
  logic [EW-1:0] rd_entry;

  rht_ctrl #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .OWNERS       (OWNERS),
    .SLOTS        (SLOTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .pool_req       (pool_req),
    .pool_entry_req (pool_entry_req),
    .pool_rsp       (pool_rsp),
    .pool_entry     (pool_entry),
    .slot_ctl       (slot_ctl),
    .rd_idx         (rd_idx),
    .wr_idx         (wr_idx),
    .wr_entry       (wr_entry),
    .rd_valid       (rd_valid),
    .rd_entry       (rd_entry)
  );

  rht_pool #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_pool (
    .clk       (clk),
    .rst       (rst),
    .req       (pool_req),
    .req_entry (pool_entry_req),
    .rsp       (pool_rsp),
    .rsp_entry (pool_entry)
  );

  rht_slot_store #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .OWNERS       (OWNERS),
    .SLOTS        (SLOTS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (slot_ctl),
    .rd_idx   (rd_idx),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry)
  );

endmodule

// ===== sv/rht_checker.sv =====
// ----------------------------------------------------------------------------
// Handle table port checker
// Watches the top-level ports for result word and handshake consistency.
// ----------------------------------------------------------------------------
module rht_checker
  import rht_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A result word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed or dropped while stalled");

  // Only one command is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new command taken while one is in progress");

  // A newly allocated entry is only ever reported with an ok status.
  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.entry_valid |-> out_word.status == ST_OK)
    else $error("entry reported with a failing status");

  // Without a new entry, the entry and slot fields read as zero.
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.entry_valid |-> out_word.entry_out == '0 && out_word.slot_out == '0)
    else $error("stale entry or slot in result word");

endmodule

bind refcounted_handle_table_top rht_checker u_rht_checker (.*);
